// ----- hw/rtl/srr_pkg.sv -----
// Shared types and constants for the selective-repeat receiver.
package srr_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int SEQ_W           = 10;
  localparam int CSUM_W          = 14;
  localparam int PAY_W           = 160;
  localparam int WIN_W           = 6;
  localparam logic [WIN_W-1:0] WIN_RESET = 6'd8;
  localparam int QDEPTH          = 2;

  // one classified packet waiting for the window logic
  typedef struct packed {
    logic             ok;
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hw/rtl/srr_front.sv -----
// Front end: accepts packets, sums the checksum and pushes good/bad words to the queue; empty packets are dropped.
module srr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [srr_pkg::SEQ_W-1:0]           in_seq_num,
  input  logic [srr_pkg::SEQ_W-1:0]           in_ack_num,
  input  logic signed [srr_pkg::CSUM_W-1:0]   in_checksum,
  input  logic [63:0]                         in_payload_lo,
  input  logic [63:0]                         in_payload_mid,
  input  logic [31:0]                         in_payload_hi,
  input  logic                                clr_busy,
  input  srr_pkg::q_stat_t                    q_stat,
  output logic                                push,
  output srr_pkg::entry_t                     push_data
);

  function automatic logic signed [10:0] sum_bytes8(input logic [63:0] w);
    logic signed [10:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc = acc + {{3{w[8*i+7]}}, w[8*i +: 8]};
    end
    return acc;
  endfunction

  function automatic logic signed [9:0] sum_bytes4(input logic [31:0] w);
    logic signed [9:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      acc = acc + {{2{w[8*i+7]}}, w[8*i +: 8]};
    end
    return acc;
  endfunction

  logic                                s1_valid_r, s1_valid_nxt;
  logic [srr_pkg::SEQ_W-1:0]           s1_seq_r;
  logic signed [srr_pkg::CSUM_W-1:0]   s1_csum_r;
  logic [srr_pkg::PAY_W-1:0]           s1_pay_r;
  logic signed [10:0]                  s1_slo_r, s1_smid_r;
  logic signed [12:0]                  s1_shi_r;
  logic signed [9:0]                   hi_sum;
  logic signed [srr_pkg::CSUM_W-1:0]   total;
  logic                                accept;
  logic                                nonempty;

  assign in_stall = clr_busy || (s1_valid_r && q_stat.full);
  assign accept   = in_valid && !in_stall;
  assign nonempty = (in_payload_lo[7:0] != 8'd0);
  assign hi_sum   = sum_bytes4(in_payload_hi);

  assign push = s1_valid_r && !q_stat.full;

  always_comb begin
    total = {{3{s1_slo_r[10]}}, s1_slo_r} + {{3{s1_smid_r[10]}}, s1_smid_r}
          + {s1_shi_r[12], s1_shi_r};
    push_data.ok      = (total == s1_csum_r);
    push_data.seq     = s1_seq_r;
    push_data.payload = s1_pay_r;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = nonempty;   // empty packets vanish here
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_seq_r  <= in_seq_num;
      s1_csum_r <= in_checksum;
      s1_pay_r  <= {in_payload_hi, in_payload_mid, in_payload_lo};
      s1_slo_r  <= sum_bytes8(in_payload_lo);
      s1_smid_r <= sum_bytes8(in_payload_mid);
      s1_shi_r  <= {{3{hi_sum[9]}}, hi_sum} + {3'b000, in_seq_num} + {3'b000, in_ack_num};
    end
  end

endmodule

// ----- hw/rtl/srr_queue.sv -----
// Short queue between the front end and the window sequencer.
module srr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srr_pkg::entry_t   push_data,
  input  logic              pop,
  output srr_pkg::entry_t   head,
  output srr_pkg::q_stat_t  stat
);

  localparam int PW   = (srr_pkg::QDEPTH > 1) ? $clog2(srr_pkg::QDEPTH) : 1;
  localparam int CNTW = $clog2(srr_pkg::QDEPTH + 1);

  srr_pkg::entry_t mem_r [srr_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNTW'(srr_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(srr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(srr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/srr_back.sv -----
// Window sequencer: marks and payload store, acks, in-order delivery, output register.
module srr_back #(
  parameter int STORE_DEPTH = srr_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [srr_pkg::WIN_W-1:0]     cfg_data,
  input  srr_pkg::entry_t               head,
  input  srr_pkg::q_stat_t              q_stat,
  output logic                          pop,
  output logic                          clr_busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [srr_pkg::SEQ_W-1:0]     out_ack_value,
  output logic [63:0]                   out_payload_lo,
  output logic [63:0]                   out_payload_mid,
  output logic [31:0]                   out_payload_hi,
  output logic                          out_last
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int BW = $clog2(STORE_DEPTH + 1);
  localparam int CW = ($clog2(STORE_DEPTH + 64) > srr_pkg::SEQ_W) ?
                      $clog2(STORE_DEPTH + 64) : srr_pkg::SEQ_W;
  localparam int PW = srr_pkg::PAY_W;
  localparam int WW = srr_pkg::WIN_W;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_RDA  = 3'd3;
  localparam logic [2:0] S_ACK  = 3'd4;
  localparam logic [2:0] S_RDD  = 3'd5;
  localparam logic [2:0] S_DLV  = 3'd6;

  logic [2:0]                 state_r, state_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic [BW-1:0]              base_r, base_nxt;
  logic [WW-1:0]              count_r, count_nxt;
  logic [WW-1:0]              win_r;
  logic                       w_ok_r;
  logic [srr_pkg::SEQ_W-1:0]  w_seq_r;
  logic [PW-1:0]              w_pay_r;

  logic                       mark_mem [STORE_DEPTH];
  logic [PW-1:0]              pay_mem  [STORE_DEPTH];
  logic                       rd_mark0_r, rd_mark1_r;
  logic [PW-1:0]              rd_pay_r;
  logic [AW-1:0]              base_a, base_a1;

  logic                       mark_we, mark_wd, st_we;
  logic [AW-1:0]              mark_wa;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_kind_r;
  logic [srr_pkg::SEQ_W-1:0]  out_ack_r;
  logic [PW-1:0]              out_pay_r;
  logic                       out_last_r;

  logic                       out_free, emit;
  logic                       e_kind, e_last;
  logic [srr_pkg::SEQ_W-1:0]  e_ack;
  logic [PW-1:0]              e_pay;

  logic [CW-1:0]              seq_x, base_x, end_x;
  logic                       in_win, old_pkt, ack_cont, dlv_cont;

  assign clr_busy = (state_r == S_CLR);
  assign base_a   = base_r[AW-1:0];
  assign base_a1  = base_a + 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  assign seq_x   = CW'(w_seq_r);
  assign base_x  = CW'(base_r);
  assign end_x   = base_x + CW'(win_r);
  assign in_win  = w_ok_r && (seq_x >= base_x) && (seq_x < end_x)
                && (seq_x < CW'(STORE_DEPTH));
  assign old_pkt = (seq_x < base_x);

  // read data is registered: it reflects the base of the previous cycle
  assign ack_cont = rd_mark0_r && (win_r != '0) && (base_r != BW'(STORE_DEPTH));
  assign dlv_cont = rd_mark1_r && (({1'b0, count_r} + 1'b1) < {1'b0, win_r})
                 && (base_r != BW'(STORE_DEPTH - 1));

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    base_nxt     = base_r;
    count_nxt    = count_r;
    pop          = 1'b0;
    mark_we      = 1'b0;
    mark_wa      = AW'(w_seq_r);
    mark_wd      = 1'b1;
    st_we        = 1'b0;
    emit         = 1'b0;
    e_kind       = KIND_ACK;
    e_ack        = w_seq_r;
    e_pay        = '0;
    e_last       = 1'b1;
    unique case (state_r)
      S_CLR: begin
        mark_we      = 1'b1;
        mark_wa      = clr_addr_r;
        mark_wd      = 1'b0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        priority if (in_win) begin
          mark_we   = 1'b1;
          st_we     = 1'b1;
          count_nxt = '0;
          state_nxt = S_RDA;
        end else if (old_pkt) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RDA: begin
        state_nxt = S_ACK;
      end
      S_ACK: begin
        if (out_free) begin
          emit      = 1'b1;
          e_last    = !ack_cont;
          state_nxt = ack_cont ? S_DLV : S_IDLE;
        end
      end
      S_RDD: begin
        state_nxt = S_DLV;
      end
      S_DLV: begin
        e_kind = KIND_DLV;
        e_ack  = '0;
        e_pay  = rd_pay_r;
        e_last = !dlv_cont;
        if (out_free) begin
          emit      = 1'b1;
          base_nxt  = base_r + 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = dlv_cont ? S_RDD : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      base_r      <= '0;
      count_r     <= '0;
      win_r       <= srr_pkg::WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        win_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_ok_r  <= head.ok;
      w_seq_r <= head.seq;
      w_pay_r <= head.payload;
    end
    if (emit) begin
      out_kind_r <= e_kind;
      out_ack_r  <= e_ack;
      out_pay_r  <= e_pay;
      out_last_r <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    rd_mark0_r <= mark_mem[base_a];
    rd_mark1_r <= mark_mem[base_a1];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      pay_mem[AW'(w_seq_r)] <= w_pay_r;
    end
    rd_pay_r <= pay_mem[base_a];
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_ack_value   = out_ack_r;
  assign out_payload_lo  = out_pay_r[63:0];
  assign out_payload_mid = out_pay_r[127:64];
  assign out_payload_hi  = out_pay_r[159:128];
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= BW'(STORE_DEPTH))
    else $error("window base past store depth");

  a_dlv_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DLV) |-> rd_mark0_r)
    else $error("delivery from an unmarked entry");

  a_dlv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DLV) |-> (count_r < win_r))
    else $error("delivery run longer than the window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_valid_r) |-> !out_stall)
    else $error("result word overwritten while stalled");
`endif

endmodule

// ----- hw/rtl/selective_repeat_receiver_core.sv -----
// An in-window packet passes the front-end register, the queue, S_IDLE, S_DEC, S_RDA and S_ACK;
//   an old one is re-acked from S_DEC. The window sequencer pops only in S_IDLE and finishes a packet
//   and its deliveries (S_DLV, S_RDD before each further one: registered mark/payload reads) first.
// Reset: synchronous, active low; afterwards a clearing pass over the mark memory
//   writes every entry, during which no packet is accepted (config writes are).
// Top level: front end, queue and window sequencer.
module selective_repeat_receiver_core #(
  parameter int STORE_DEPTH = srr_pkg::STORE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [srr_pkg::WIN_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [srr_pkg::SEQ_W-1:0]           in_seq_num,
  input  logic [srr_pkg::SEQ_W-1:0]           in_ack_num,
  input  logic signed [srr_pkg::CSUM_W-1:0]   in_checksum,
  input  logic [63:0]                         in_payload_lo,
  input  logic [63:0]                         in_payload_mid,
  input  logic [31:0]                         in_payload_hi,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [srr_pkg::SEQ_W-1:0]           out_ack_value,
  output logic [63:0]                         out_payload_lo,
  output logic [63:0]                         out_payload_mid,
  output logic [31:0]                         out_payload_hi,
  output logic                                out_last
);

  logic              push, pop, clr_busy;
  srr_pkg::entry_t   push_data, head;
  srr_pkg::q_stat_t  q_stat;

  srr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_seq_num     (in_seq_num),
    .in_ack_num     (in_ack_num),
    .in_checksum    (in_checksum),
    .in_payload_lo  (in_payload_lo),
    .in_payload_mid (in_payload_mid),
    .in_payload_hi  (in_payload_hi),
    .clr_busy       (clr_busy),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  srr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  srr_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .clr_busy        (clr_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_ack_value   (out_ack_value),
    .out_payload_lo  (out_payload_lo),
    .out_payload_mid (out_payload_mid),
    .out_payload_hi  (out_payload_hi),
    .out_last        (out_last)
  );

endmodule
